/* src/actr_pkg.sv */
// Package: AES-128 constants, S-box and round helper functions.
package actr_pkg;

   localparam int BLOCK_BITS = 128;
   localparam int NUM_ROUNDS = 10;
   localparam int KEY_BITS   = 64;
   localparam int CNT_BITS   = 5;
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_LOW  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_HIGH = 1'b1;
   localparam logic [63:0] INDEX_START = 64'd1;
   localparam logic [CNT_BITS-1:0] FULL_BYTES = 5'd16;

   typedef logic [BLOCK_BITS-1:0] block_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] tab [0:255];
      tab = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tab[a];
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte b sits in bits 8b+7:8b.
   function automatic logic [7:0] byte_of(input block_type s, input int b);
      return s[8*b +: 8];
   endfunction

   // Next round key from the previous one.
   function automatic block_type next_key(input block_type k, input logic [3:0] r);
      block_type n;
      logic [31:0] t;
      t = {sbox(k[103:96]), sbox(k[127:120]), sbox(k[119:112]),
           sbox(k[111:104]) ^ rcon(r)};
      n[31:0]   = k[31:0] ^ t;
      n[63:32]  = k[63:32] ^ n[31:0];
      n[95:64]  = k[95:64] ^ n[63:32];
      n[127:96] = k[127:96] ^ n[95:64];
      return n;
   endfunction

   // SubBytes, ShiftRows and, unless final, MixColumns.
   function automatic block_type round_fn(input block_type s, input logic final_rnd);
      block_type t;
      block_type m;
      logic [7:0] a0, a1, a2, a3, al;
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[8*(c*4+i) +: 8] = sbox(byte_of(s, ((c + i) % 4) * 4 + i));
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[8*(c*4) +: 8];
         a1 = t[8*(c*4+1) +: 8];
         a2 = t[8*(c*4+2) +: 8];
         a3 = t[8*(c*4+3) +: 8];
         al = a0 ^ a1 ^ a2 ^ a3;
         m[8*(c*4) +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
         m[8*(c*4+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
         m[8*(c*4+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
         m[8*(c*4+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      return final_rnd ? t : m;
   endfunction

endpackage

/* src/actr_if.sv */
// Interfaces: request and response word channels.
interface actr_req_if import actr_pkg::*; (input logic clock);
   logic                valid;
   logic                ready;
   logic [63:0]         data_low;
   logic [63:0]         data_high;
   logic [CNT_BITS-1:0] byte_count;
   logic                last_block;
   modport source (output valid, data_low, data_high, byte_count, last_block, input ready);
   modport sink (input valid, data_low, data_high, byte_count, last_block, output ready);
endinterface

interface actr_rsp_if import actr_pkg::*; (input logic clock);
   logic                valid;
   logic                ready;
   logic [63:0]         out_low;
   logic [63:0]         out_high;
   logic [CNT_BITS-1:0] out_count;
   logic                out_last;
   modport source (output valid, out_low, out_high, out_count, out_last, input ready);
   modport sink (input valid, out_low, out_high, out_count, out_last, output ready);
endinterface

/* src/actr_keysched.sv */
// Key schedule: round keys held in registers, rebuilt one round per cycle.
module actr_keysched import actr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [KEY_BITS-1:0]     csr_data,
   output block_type               round_keys [0:NUM_ROUNDS],
   output logic                    keys_ready
);
   localparam logic [3:0] SETTLE_CYCLES = 4'(NUM_ROUNDS + 1);

   logic [KEY_BITS-1:0] key_low_ff, key_high_ff;
   logic [3:0]          settle_ff;
   block_type           rk_ff [0:NUM_ROUNDS];
   block_type           rk_in [0:NUM_ROUNDS];

   // Each key register rebuilds from its predecessor.
   always_comb begin
      rk_in[0] = {key_high_ff, key_low_ff};
      for (int r = 1; r <= NUM_ROUNDS; r++) begin
         rk_in[r] = next_key(rk_ff[r-1], 4'(r));
      end
   end

   // Reload the settle count after reset or a key write and count it down until the last round key is good.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         settle_ff   <= SETTLE_CYCLES;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_data;
            CSR_KEY_HIGH: key_high_ff <= csr_data;
            default: ;
         endcase
         settle_ff <= SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - 4'd1;
      end
      rk_ff <= rk_in;
   end

   assign round_keys = rk_ff;
   assign keys_ready = (settle_ff == '0);
endmodule

/* src/aes128_counter_mode_xor_core.sv */
// Top level: AES-128 counter-mode XOR engine, one word per cycle while not stalled.
//
//   channel  dir  handshake       payload
//   req      in   valid/ready     data_low, data_high, byte_count, last_block
//   rsp      out  valid/ready     out_low, out_high, out_count, out_last
//   csr      in   csr_write       csr_index, csr_data (key_low, key_high)
//
// One word enters per cycle while rsp does not stall and the keys are ready;
// the pipe is a key-add stage and ten round stages, with result XOR and mask
// taken straight off the last stage. Each round stage holds one AES round.
// Reset is synchronous; the block index returns to 1 and the round keys
// rebuild from the zero key. After reset or a key write, req.ready stays low
// while the schedule settles. A stall at rsp freezes the whole pipeline, so
// nothing is dropped or repeated.
module aes128_counter_mode_xor_core import actr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   actr_req_if.sink                req,
   actr_rsp_if.source              rsp,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [KEY_BITS-1:0]     csr_data
);
   localparam int STAGES = NUM_ROUNDS + 1;

   typedef struct packed {
      logic [127:0]        data;
      logic [CNT_BITS-1:0] count;
      logic                last;
   } side_type;

   block_type round_keys [0:NUM_ROUNDS];
   logic      keys_ready;
   logic      [63:0] index_ff, index_in;
   logic      [STAGES-1:0] vld_ff;
   block_type st_ff   [0:STAGES-1];
   side_type  side_ff [0:STAGES-1];
   logic      adv;
   logic      accept;
   block_type ctr;
   block_type mask;
   logic [127:0] res;

   actr_keysched u_keys (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .round_keys, .keys_ready
   );

   // Advance the pipe when the last stage is empty or being taken.
   assign adv       = !vld_ff[STAGES-1] || rsp.ready;
   assign req.ready = adv && keys_ready;
   assign accept    = req.valid && adv && keys_ready;

   // Counter block: little-endian index in bytes 0..7, zeros above.
   assign ctr      = {64'd0, index_ff};
   assign index_in = req.last_block ? INDEX_START : index_ff + 64'd1;

   // Build a byte mask from the valid count (counts above 16 saturate).
   always_comb begin
      for (int b = 0; b < 16; b++) begin
         mask[8*b +: 8] = (5'(b) < req.byte_count) ? 8'hFF : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= INDEX_START;
         vld_ff   <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], accept};
         if (accept) begin
            index_ff <= index_in;
         end
      end
   end

   // Payload stages: stage 0 adds round key 0; stage r applies round r.
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0]         <= ctr ^ round_keys[0];
         side_ff[0].data  <= {req.data_high, req.data_low} & mask;
         side_ff[0].count <= req.byte_count;
         side_ff[0].last  <= req.last_block;
         for (int r = 1; r < STAGES; r++) begin
            st_ff[r]   <= round_fn(st_ff[r-1], r == NUM_ROUNDS) ^ round_keys[r];
            side_ff[r] <= side_ff[r-1];
         end
      end
   end

   // XOR data with the keystream and zero the result where data is masked off.
   always_comb begin
      for (int b = 0; b < 16; b++) begin
         res[8*b +: 8] = (side_ff[STAGES-1].data[8*b +: 8] ^ st_ff[STAGES-1][8*b +: 8])
                         & ((5'(b) < side_ff[STAGES-1].count) ? 8'hFF : 8'h00);
      end
   end

   assign rsp.valid     = vld_ff[STAGES-1];
   assign rsp.out_low   = res[63:0];
   assign rsp.out_high  = res[127:64];
   assign rsp.out_count = side_ff[STAGES-1].count;
   assign rsp.out_last  = side_ff[STAGES-1].last;
endmodule
